// ===== hdl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, operation and status codes, and the segment entry type.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned MAX_SEGMENTS = 64;
  localparam logic [31:0] HEAP_BASE    = 32'h0020_0000;
  localparam int unsigned HEAP_BYTES   = 1048576;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned HEADER_BYTES = 12;

  localparam int OFF_W  = 20;
  localparam int SIZE_W = 21;
  localparam int ADDR_W = 32;

  localparam logic [SIZE_W-1:0] HDR_SIZE   = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HEAP_LIMIT = SIZE_W'(HEAP_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SIZE  = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [SIZE_W:0]   ALIGN_M1   = (SIZE_W+1)'(ALIGN_BYTES - 1);
  localparam logic [SIZE_W:0]   SPLIT_MIN  = (SIZE_W+1)'(HEADER_BYTES + ALIGN_BYTES);

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REALLOC = 2'd2,
    FUNC_STATS   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic              free;
  } seg_t;

  function automatic logic [ADDR_W-1:0] payload_addr(input logic [OFF_W-1:0] off);
    return HEAP_BASE + ADDR_W'(HEADER_BYTES) + {{(ADDR_W-OFF_W){1'b0}}, off};
  endfunction

endpackage

// ===== hdl/ffha_table.sv =====
// ----------------------------------------------------------------------------
// Segment table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_table #(
  parameter int unsigned DEPTH = ffha_pkg::MAX_SEGMENTS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  ffha_pkg::seg_t           wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output ffha_pkg::seg_t           rd_data
);
  import ffha_pkg::*;

  seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Sequencer over an address-ordered segment table with split and coalescing.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel: in_tuser carries the operation (allocate,
// free, reallocate, statistics), in_tdata the payload address and request size.
// Exactly one result transfer follows each request on the out_ channel, with the
// returned address, copy length, used and free byte totals, and status in
// out_tuser. The block serves one request at a time; in_tready is high only
// while it is idle. Each table entry visited takes a read state and then a use
// state. A first-fit search walks the entries in order; a split moves each
// entry above the chosen one up one place, and a free with coalescing moves
// each later entry down one place, all through the single table port. A
// finished result waits in the output register while the receiver stalls;
// the sequencer holds a further result until the earlier one is taken.
// After reset the block writes the initial free segment in its init state and
// then accepts requests. Running totals of used and free bytes are kept in
// registers, so statistics cost no table walk.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // address[31:0], request_size[52:32], zero pad
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // result_address[31:0], copy_length[52:32],
                                  // used_bytes[73:53], spare_bytes[94:74], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

  typedef enum logic [16:0] {
    S_INIT   = 17'h00001,
    S_IDLE   = 17'h00002,
    S_F_RD   = 17'h00004,
    S_F_CMP  = 17'h00008,
    S_A_RD   = 17'h00010,
    S_A_CMP  = 17'h00020,
    S_SU_RD  = 17'h00040,
    S_SU_WR  = 17'h00080,
    S_A_WN   = 17'h00100,
    S_A_WC   = 17'h00200,
    S_FR_ACC = 17'h00400,
    S_FR_NX  = 17'h00800,
    S_FR_NXC = 17'h01000,
    S_FR_PV  = 17'h02000,
    S_FR_PVC = 17'h04000,
    S_SD     = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [SIZE_W-1:0] sz_r, sz_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     fidx_r, fidx_nxt;
  logic [SIZE_W-1:0] alloc_r, alloc_nxt;
  logic [SIZE_W-1:0] fsum_r, fsum_nxt;
  logic [OFF_W-1:0]  cur_off_r, cur_off_nxt;
  logic [SIZE_W-1:0] cur_size_r, cur_size_nxt;
  logic [OFF_W-1:0]  old_off_r, old_off_nxt;
  logic [SIZE_W-1:0] old_size_r, old_size_nxt;
  logic [ADDR_W-1:0] res_r, res_nxt;
  logic [SIZE_W-1:0] copy_r, copy_nxt;
  status_t           status_r, status_nxt;
  logic              realloc_r, realloc_nxt;
  logic              move_r, move_nxt;
  logic              split_r, split_nxt;
  logic              ret_pv_r, ret_pv_nxt;
  logic              sd_wr_r, sd_wr_nxt;

  logic              out_valid_r;
  logic [95:0]       out_data_r;
  status_t           out_status_r;
  logic              out_load;

  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  seg_t              mem_wdata, mem_rdata;

  func_t             in_func;
  logic [ADDR_W-1:0] in_addr;
  logic [SIZE_W-1:0] in_req;
  logic [SIZE_W-1:0] in_sz;
  logic [SIZE_W-1:0] req_sz;
  logic [CW-1:0]     fidx_ext;

  ffha_table #(
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_func  = func_t'(in_tuser);
  assign in_addr  = in_tdata[31:0];
  assign in_req   = in_tdata[52:32];
  assign in_sz    = SIZE_W'(({1'b0, in_req} + ALIGN_M1) & ~ALIGN_M1);
  assign req_sz   = SIZE_W'(({1'b0, req_r} + ALIGN_M1) & ~ALIGN_M1);
  assign fidx_ext = CW'(fidx_r);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    req_nxt      = req_r;
    sz_nxt       = sz_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    count_nxt    = count_r;
    fidx_nxt     = fidx_r;
    alloc_nxt    = alloc_r;
    fsum_nxt     = fsum_r;
    cur_off_nxt  = cur_off_r;
    cur_size_nxt = cur_size_r;
    old_off_nxt  = old_off_r;
    old_size_nxt = old_size_r;
    res_nxt      = res_r;
    copy_nxt     = copy_r;
    status_nxt   = status_r;
    realloc_nxt  = realloc_r;
    move_nxt     = move_r;
    split_nxt    = split_r;
    ret_pv_nxt   = ret_pv_r;
    sd_wr_nxt    = sd_wr_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    out_load     = 1'b0;

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{off: '0, size: INIT_SIZE, free: 1'b1};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_tvalid) begin
          addr_nxt    = in_addr;
          req_nxt     = in_req;
          sz_nxt      = in_sz;
          idx_nxt     = '0;
          res_nxt     = '0;
          copy_nxt    = '0;
          status_nxt  = ST_OK;
          move_nxt    = 1'b0;
          realloc_nxt = 1'b0;
          state_nxt   = S_DONE;
          if (in_func == FUNC_ALLOC || (in_func == FUNC_REALLOC && in_addr == '0)) begin
            if (in_req > HEAP_LIMIT) begin
              status_nxt = ST_NOMEM;
            end else if (in_req != '0) begin
              state_nxt = S_A_RD;
            end
          end else if (in_func == FUNC_FREE || (in_func == FUNC_REALLOC && in_req == '0)) begin
            if (in_addr != '0) begin
              state_nxt = S_F_RD;
            end
          end else if (in_func == FUNC_REALLOC) begin
            realloc_nxt = 1'b1;
            state_nxt   = S_F_RD;
          end
        end
      end

      // Look up the allocated segment that owns the given payload address.
      S_F_RD: begin
        if (idx_r == count_r) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r[IW-1:0];
          state_nxt = S_F_CMP;
        end
      end

      S_F_CMP: begin
        if (payload_addr(mem_rdata.off) == addr_r) begin
          if (mem_rdata.free) begin
            status_nxt = ST_INVALID;
            state_nxt  = S_DONE;
          end else if (!realloc_r) begin
            cur_off_nxt  = mem_rdata.off;
            cur_size_nxt = mem_rdata.size;
            fidx_nxt     = idx_r[IW-1:0];
            state_nxt    = S_FR_ACC;
          end else if (mem_rdata.size >= req_r) begin
            res_nxt   = addr_r;
            state_nxt = S_DONE;
          end else if (req_r > HEAP_LIMIT) begin
            status_nxt = ST_NOMEM;
            state_nxt  = S_DONE;
          end else begin
            old_off_nxt  = mem_rdata.off;
            old_size_nxt = mem_rdata.size;
            fidx_nxt     = idx_r[IW-1:0];
            move_nxt     = 1'b1;
            sz_nxt       = req_sz;
            idx_nxt      = '0;
            state_nxt    = S_A_RD;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_F_RD;
        end
      end

      // First-fit search.
      S_A_RD: begin
        if (idx_r == count_r) begin
          status_nxt = ST_NOMEM;
          state_nxt  = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r[IW-1:0];
          state_nxt = S_A_CMP;
        end
      end

      S_A_CMP: begin
        if (mem_rdata.free && mem_rdata.size >= sz_r) begin
          cur_off_nxt  = mem_rdata.off;
          cur_size_nxt = mem_rdata.size;
          if (count_r < CNT_MAX && {1'b0, mem_rdata.size} >= ({1'b0, sz_r} + SPLIT_MIN)) begin
            split_nxt = 1'b1;
            k_nxt     = count_r - CW'(1);
            state_nxt = S_SU_RD;
          end else begin
            split_nxt = 1'b0;
            state_nxt = S_A_WC;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_A_RD;
        end
      end

      // Open a gap above the chosen segment, moving the top entry first.
      S_SU_RD: begin
        if (k_r > idx_r) begin
          mem_re    = 1'b1;
          mem_raddr = k_r[IW-1:0];
          state_nxt = S_SU_WR;
        end else begin
          state_nxt = S_A_WN;
        end
      end

      S_SU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(k_r + CW'(1));
        mem_wdata = mem_rdata;
        k_nxt     = k_r - CW'(1);
        state_nxt = S_SU_RD;
      end

      S_A_WN: begin
        mem_we       = 1'b1;
        mem_waddr    = IW'(idx_r + CW'(1));
        mem_wdata    = '{off:  OFF_W'(cur_off_r + OFF_W'(HEADER_BYTES) + sz_r[OFF_W-1:0]),
                         size: cur_size_r - sz_r - HDR_SIZE,
                         free: 1'b1};
        count_nxt    = count_r + CW'(1);
        cur_size_nxt = sz_r;
        fsum_nxt     = fsum_r - sz_r - HDR_SIZE;
        state_nxt    = S_A_WC;
      end

      S_A_WC: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[IW-1:0];
        mem_wdata = '{off: cur_off_r, size: cur_size_r, free: 1'b0};
        alloc_nxt = alloc_r + cur_size_r;
        if (!split_r) begin
          fsum_nxt = fsum_r - cur_size_r;
        end
        res_nxt   = payload_addr(cur_off_r);
        state_nxt = S_DONE;
        if (move_r) begin
          // The old block now follows the new one by one more place if a split
          // opened a gap below it.
          copy_nxt     = old_size_r;
          cur_off_nxt  = old_off_r;
          cur_size_nxt = old_size_r;
          if (split_r && idx_r < fidx_ext) begin
            fidx_nxt = fidx_r + IW'(1);
          end
          state_nxt = S_FR_ACC;
        end
      end

      S_FR_ACC: begin
        alloc_nxt = (alloc_r >= cur_size_r) ? alloc_r - cur_size_r : '0;
        fsum_nxt  = fsum_r + cur_size_r;
        state_nxt = S_FR_NX;
      end

      // Coalesce with the following segment, then with the preceding one.
      S_FR_NX: begin
        if (fidx_ext + CW'(1) < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = fidx_r + IW'(1);
          state_nxt = S_FR_NXC;
        end else begin
          state_nxt = S_FR_PV;
        end
      end

      S_FR_NXC: begin
        if (mem_rdata.free) begin
          cur_size_nxt = cur_size_r + HDR_SIZE + mem_rdata.size;
          fsum_nxt     = fsum_r + HDR_SIZE;
          k_nxt        = fidx_ext + CW'(1);
          ret_pv_nxt   = 1'b1;
          sd_wr_nxt    = 1'b0;
          state_nxt    = S_SD;
        end else begin
          state_nxt = S_FR_PV;
        end
      end

      S_FR_PV: begin
        if (fidx_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = fidx_r - IW'(1);
          state_nxt = S_FR_PVC;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = fidx_r;
          mem_wdata = '{off: cur_off_r, size: cur_size_r, free: 1'b1};
          state_nxt = S_DONE;
        end
      end

      S_FR_PVC: begin
        mem_we = 1'b1;
        if (mem_rdata.free) begin
          mem_waddr  = fidx_r - IW'(1);
          mem_wdata  = '{off:  mem_rdata.off,
                         size: mem_rdata.size + HDR_SIZE + cur_size_r,
                         free: 1'b1};
          fsum_nxt   = fsum_r + HDR_SIZE;
          k_nxt      = fidx_ext;
          ret_pv_nxt = 1'b0;
          sd_wr_nxt  = 1'b0;
          state_nxt  = S_SD;
        end else begin
          mem_waddr = fidx_r;
          mem_wdata = '{off: cur_off_r, size: cur_size_r, free: 1'b1};
          state_nxt = S_DONE;
        end
      end

      // Close the gap at entry k by moving every later entry down one place.
      S_SD: begin
        if (sd_wr_r) begin
          mem_we    = 1'b1;
          mem_waddr = k_r[IW-1:0];
          mem_wdata = mem_rdata;
          k_nxt     = k_r + CW'(1);
          sd_wr_nxt = 1'b0;
        end else if (k_r + CW'(1) < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = IW'(k_r + CW'(1));
          sd_wr_nxt = 1'b1;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = ret_pv_r ? S_FR_PV : S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      count_r   <= CW'(1);
      alloc_r   <= '0;
      fsum_r    <= INIT_SIZE;
      realloc_r <= 1'b0;
      move_r    <= 1'b0;
      split_r   <= 1'b0;
      ret_pv_r  <= 1'b0;
      sd_wr_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      alloc_r   <= alloc_nxt;
      fsum_r    <= fsum_nxt;
      realloc_r <= realloc_nxt;
      move_r    <= move_nxt;
      split_r   <= split_nxt;
      ret_pv_r  <= ret_pv_nxt;
      sd_wr_r   <= sd_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    req_r      <= req_nxt;
    sz_r       <= sz_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    fidx_r     <= fidx_nxt;
    cur_off_r  <= cur_off_nxt;
    cur_size_r <= cur_size_nxt;
    old_off_r  <= old_off_nxt;
    old_size_r <= old_size_nxt;
    res_r      <= res_nxt;
    copy_r     <= copy_nxt;
    status_r   <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= {1'b0, fsum_r, alloc_r, copy_r, res_r};
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_MAX))
    else $error("segment count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while a request is in progress");

  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[31:0] == '0))
    else $error("failed request returned an address");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NOMEM || out_tuser == ST_INVALID))
    else $error("undefined status code");

endmodule

// ===== tb/sv/first_fit_heap_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate, free, reallocate and statistics requests through the stream
// ports, predicts every result with its own segment table model and compares
// each result transfer field by field, with random bursts and output stalls.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  typedef struct packed {
    logic [31:0] addr;
    logic [20:0] copy;
    logic [20:0] used;
    logic [20:0] free_b;
    logic [1:0]  status;
  } heap_result_t;

  class heap_scoreboard;
    logic [31:0] seg_off [MAX_SEGMENTS];
    logic [20:0] seg_size [MAX_SEGMENTS];
    bit          seg_free [MAX_SEGMENTS];
    int unsigned seg_count;
    logic [20:0] used_total;
    heap_result_t pending [$];
    int unsigned errors;
    int unsigned checked;
    logic [31:0] live [$];

    function void clear();
      foreach (seg_off[i]) begin
        seg_off[i] = 0; seg_size[i] = 0; seg_free[i] = 0;
      end
      seg_size[0] = 21'(HEAP_BYTES - HEADER_BYTES);
      seg_free[0] = 1;
      seg_count = 1;
      used_total = 0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] addr_of(int i);
      return HEAP_BASE + HEADER_BYTES + seg_off[i];
    endfunction

    function int lookup(logic [31:0] a);
      for (int i = 0; i < seg_count; i++)
        if (addr_of(i) == a) return i;
      return -1;
    endfunction

    function void coalesce();
      int i;
      i = 0;
      while (i + 1 < seg_count) begin
        if (seg_free[i] && seg_free[i+1]) begin
          seg_size[i] = 21'(seg_size[i] + HEADER_BYTES + seg_size[i+1]);
          for (int j = i + 1; j + 1 < seg_count; j++) begin
            seg_off[j] = seg_off[j+1]; seg_size[j] = seg_size[j+1];
            seg_free[j] = seg_free[j+1];
          end
          seg_count--;
        end else i++;
      end
    endfunction

    function status_t allocate(logic [20:0] req, output logic [31:0] a);
      logic [21:0] sz;
      a = 0;
      if (req == 0) return ST_OK;
      if (req > HEAP_BYTES) return ST_NOMEM;
      sz = 22'(((22'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);
      for (int i = 0; i < seg_count; i++) begin
        if (seg_free[i] && 22'(seg_size[i]) >= sz) begin
          if (seg_count < MAX_SEGMENTS &&
              22'(seg_size[i]) >= sz + HEADER_BYTES + ALIGN_BYTES) begin
            for (int j = seg_count; j > i + 1; j--) begin
              seg_off[j] = seg_off[j-1]; seg_size[j] = seg_size[j-1];
              seg_free[j] = seg_free[j-1];
            end
            seg_off[i+1] = seg_off[i] + HEADER_BYTES + 32'(sz);
            seg_size[i+1] = 21'(seg_size[i] - sz - HEADER_BYTES);
            seg_free[i+1] = 1;
            seg_size[i] = sz[20:0];
            seg_count++;
          end
          seg_free[i] = 0;
          used_total = used_total + seg_size[i];
          a = addr_of(i);
          return ST_OK;
        end
      end
      return ST_NOMEM;
    endfunction

    function status_t release_block(logic [31:0] a);
      int k;
      if (a == 0) return ST_OK;
      k = lookup(a);
      if (k < 0 || seg_free[k]) return ST_INVALID;
      used_total = (used_total >= seg_size[k]) ? used_total - seg_size[k] : 21'd0;
      seg_free[k] = 1;
      coalesce();
      return ST_OK;
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(func_t f, logic [31:0] a, logic [20:0] req);
      heap_result_t r;
      int k;
      logic [20:0] old;
      r = '0;
      case (f)
        FUNC_ALLOC: r.status = allocate(req, r.addr);
        FUNC_FREE: r.status = release_block(a);
        FUNC_REALLOC: begin
          if (a == 0) r.status = allocate(req, r.addr);
          else if (req == 0) r.status = release_block(a);
          else begin
            k = lookup(a);
            if (k < 0 || seg_free[k]) r.status = ST_INVALID;
            else if (seg_size[k] >= req) r.addr = a;
            else begin
              old = seg_size[k];
              r.status = allocate(req, r.addr);
              if (r.status == ST_OK) begin
                r.copy = old;
                void'(release_block(a));
              end
            end
          end
        end
        default: ;
      endcase
      r.used = used_total;
      for (int i = 0; i < seg_count; i++)
        if (seg_free[i]) r.free_b += seg_size[i];
      pending.push_back(r);
      if (r.addr != 0 && r.addr != a) live.push_back(r.addr);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.addr !== e.addr) begin
        $display("%0t: result_address expected %h actual %h", $time, e.addr, got.addr);
        errors++;
      end
      if (got.copy !== e.copy) begin
        $display("%0t: copy_length expected %0d actual %0d", $time, e.copy, got.copy);
        errors++;
      end
      if (got.used !== e.used) begin
        $display("%0t: used_bytes expected %0d actual %0d", $time, e.used, got.used);
        errors++;
      end
      if (got.free_b !== e.free_b) begin
        $display("%0t: spare_bytes expected %0d actual %0d", $time, e.free_b, got.free_b);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic [1:0] out_tuser;

  heap_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  bit stall_mode = 0;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  first_fit_heap_allocator dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: long open stretches alternate with stretches of heavy stalling.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tdata[31:0], out_tdata[52:32], out_tdata[73:53],
                       out_tdata[94:74], out_tuser});
    if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
    out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Holds one request on the input until its transfer, with burst gaps first.
  // The valid stays up after a transfer until the next request or a gap replaces
  // it; the block is busy for at least that cycle, so nothing is taken twice.
  task automatic send(func_t f, logic [31:0] a, logic [20:0] req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 300);
      if (gap != 0) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1;
    in_tuser <= f;
    in_tdata <= {3'b0, req, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(f, a, req);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    int n;
    n = $urandom_range(0, 9);
    if (n == 0) return $urandom;
    if (n == 1) return 32'd0;
    if (sb.live.size() == 0) return HEAP_BASE + HEADER_BYTES;
    return sb.live[$urandom_range(0, sb.live.size() - 1)];
  endfunction

  function automatic logic [20:0] pick_size();
    int n;
    n = $urandom_range(0, 19);
    if (n == 0) return 21'($urandom);
    if (n == 1) return 21'($urandom_range(0, 1048576));
    if (n < 4) return 21'($urandom_range(0, 65536));
    return 21'($urandom_range(1, 256));
  endfunction

  initial begin
    logic [31:0] a;
    logic [1:0] f;
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(FUNC_STATS, 32'hFFFF_FFFF, 21'h1F_FFFF);
    send(FUNC_ALLOC, 32'd0, 21'd0);
    send(FUNC_ALLOC, 32'd0, 21'h1F_FFFF);
    send(FUNC_ALLOC, 32'd0, 21'd1048577);
    send(FUNC_ALLOC, 32'd0, 21'd1);
    send(FUNC_ALLOC, 32'd0, 21'd100);
    send(FUNC_ALLOC, 32'd0, 21'd1048576);
    send(FUNC_FREE, 32'd0, 21'd0);
    send(FUNC_FREE, 32'hFFFF_FFFF, 21'd0);
    send(FUNC_FREE, HEAP_BASE + HEADER_BYTES, 21'd0);
    send(FUNC_FREE, HEAP_BASE + HEADER_BYTES, 21'd0);
    send(FUNC_REALLOC, 32'd0, 21'd40);
    send(FUNC_REALLOC, HEAP_BASE + HEADER_BYTES, 21'd8);
    send(FUNC_REALLOC, HEAP_BASE + HEADER_BYTES, 21'd500);
    send(FUNC_REALLOC, HEAP_BASE + 32'd12345, 21'd16);
    send(FUNC_REALLOC, HEAP_BASE + HEADER_BYTES, 21'd1048500);
    send(FUNC_ALLOC, 32'd0, 21'd900000);
    send(FUNC_REALLOC, HEAP_BASE + HEADER_BYTES, 21'd0);
    // Fill the table so later allocations are taken without a split.
    for (int i = 0; i < 70; i++) send(FUNC_ALLOC, 32'd0, 21'd8);
    send(FUNC_STATS, 32'd0, 21'd0);
    drain();

    for (int i = 0; i < 500; i++) begin
      if (i == 250) drain();
      f = 2'($urandom_range(0, 3));
      a = pick_addr();
      send(func_t'(f), a, pick_size());
      if (f == FUNC_FREE && $urandom_range(0, 1) == 0) begin
        foreach (sb.live[k]) if (sb.live[k] == a) begin
          sb.live.delete(k);
          break;
        end
      end
      if (sb.live.size() > 80) void'(sb.live.pop_front());
    end

    drain();
    repeat (1000) @(posedge clk);
    $display("Sent %0d requests and checked %0d results, covering splits, a full table,",
             sent, sb.checked);
    $display("coalescing frees, moving and in-place reallocates, and invalid addresses.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
